>>> design/mmcseq_pkg.sv
// ----------------------------------------------------------------------------
// MMC SPI command sequencer package
// Phase codes, result record, command table and frame constants.
// ----------------------------------------------------------------------------
package mmcseq_pkg;

	localparam logic [12:0] MAX_BLOCK_LEN = 13'd4096;
	localparam logic [12:0] RESET_BLOCK_LEN = 13'd512;
	localparam logic [12:0] REG_BLOCK_LEN = 13'd16;
	localparam logic [4:0] LAST_INDEX = 5'd24;

	localparam logic [7:0] CMD_START_BIT = 8'h40;
	localparam logic [7:0] CRC_CMD0 = 8'h95;
	localparam logic [7:0] IDLE_BYTE = 8'hFF;
	localparam logic [7:0] START_TOKEN = 8'hFE;
	localparam logic [7:0] DRESP_MASK = 8'h11;
	localparam logic [7:0] DRESP_ACCEPT = 8'h01;

	// error codes
	localparam logic [2:0] ERR_NONE = 3'd0;
	localparam logic [2:0] ERR_RESP = 3'd1;
	localparam logic [2:0] ERR_BUSY = 3'd2;
	localparam logic [2:0] ERR_TOKEN = 3'd3;
	localparam logic [2:0] ERR_DRESP = 3'd4;
	localparam logic [2:0] ERR_INDEX = 3'd5;

	// data transfer kinds
	localparam logic [1:0] XF_NONE = 2'd0;
	localparam logic [1:0] XF_READ = 2'd1;
	localparam logic [1:0] XF_WRITE = 2'd2;

	// response kinds
	localparam logic [1:0] RS_R1 = 2'd0;
	localparam logic [1:0] RS_R1B = 2'd1;
	localparam logic [1:0] RS_R2 = 2'd2;
	localparam logic [1:0] RS_R3 = 2'd3;

	typedef enum logic [18:0] {
		PH_IDLE   = 19'h00001,
		PH_SEND   = 19'h00002,
		PH_R1     = 19'h00004,
		PH_BUSY   = 19'h00008,
		PH_R2B    = 19'h00010,
		PH_OCR    = 19'h00020,
		PH_TOKEN  = 19'h00040,
		PH_RDATA  = 19'h00080,
		PH_RCRC1  = 19'h00100,
		PH_RCRC2  = 19'h00200,
		PH_WPREP  = 19'h00400,
		PH_WTOKEN = 19'h00800,
		PH_WDATA  = 19'h01000,
		PH_WCRC1  = 19'h02000,
		PH_WCRC2  = 19'h04000,
		PH_WRESP  = 19'h08000,
		PH_WBUSY  = 19'h10000,
		PH_EXTRA  = 19'h20000,
		PH_TAIL   = 19'h40000
	} phase_t;

	typedef struct packed {
		logic [7:0] second_status;
		logic [7:0] first_status;
		logic [2:0] fault_code;
		logic       done_res;
		logic       write_taken;
		logic       read_valid;
		logic [7:0] read_byte;
		logic       chip_select;
		logic [7:0] tx_byte;
	} result_t;

	function automatic logic [5:0] tab_op(input logic [4:0] ix);
		logic [5:0] op;
		case (ix)
			5'd0: op = 6'd0;
			5'd1: op = 6'd1;
			5'd2: op = 6'd9;
			5'd3: op = 6'd10;
			5'd4: op = 6'd12;
			5'd5: op = 6'd13;
			5'd6: op = 6'd16;
			5'd7: op = 6'd17;
			5'd8: op = 6'd18;
			5'd9: op = 6'd24;
			5'd10: op = 6'd25;
			5'd11: op = 6'd27;
			5'd12: op = 6'd28;
			5'd13: op = 6'd29;
			5'd14: op = 6'd30;
			5'd15: op = 6'd32;
			5'd16: op = 6'd33;
			5'd17: op = 6'd34;
			5'd18: op = 6'd35;
			5'd19: op = 6'd36;
			5'd20: op = 6'd37;
			5'd21: op = 6'd38;
			5'd22: op = 6'd42;
			5'd23: op = 6'd58;
			5'd24: op = 6'd59;
			default: op = 6'd0;
		endcase
		return op;
	endfunction

	function automatic logic tab_has_arg(input logic [4:0] ix);
		logic a;
		case (ix) inside
			[5'd6:5'd10], [5'd12:5'd22], 5'd24: a = 1'b1;
			default: a = 1'b0;
		endcase
		return a;
	endfunction

	function automatic logic [1:0] tab_xfer(input logic [4:0] ix);
		logic [1:0] x;
		case (ix) inside
			5'd2, 5'd3, 5'd7, 5'd8: x = XF_READ;
			5'd9, 5'd10: x = XF_WRITE;
			default: x = XF_NONE;
		endcase
		return x;
	endfunction

	function automatic logic [1:0] tab_resp(input logic [4:0] ix);
		logic [1:0] r;
		case (ix) inside
			5'd5: r = RS_R2;
			5'd12, 5'd13, 5'd21, 5'd22: r = RS_R1B;
			5'd23: r = RS_R3;
			default: r = RS_R1;
		endcase
		return r;
	endfunction

	// CMD9 / CMD10 read a 16-byte register
	function automatic logic is_reg_read(input logic [4:0] ix);
		return (ix == 5'd2) || (ix == 5'd3);
	endfunction

endpackage

>>> design/mmc_spi_command_sequencer.sv
// ----------------------------------------------------------------------------
// MMC SPI command sequencer
// Steps an MMC card through one SPI-mode command per start transaction.
// ----------------------------------------------------------------------------
// Each input transaction is either a command start (tuser 0) or one finished
// SPI byte exchange (tuser 1); every input transaction yields exactly one
// result transaction carrying the next byte to send, chip select, any byte
// read from the card and, on the last result of a command (tlast), the error
// code and R1/R2 status. The block takes one transaction per clock while the
// output is not stalled; the result passes through the input register and
// then the result register, set by the single next-phase step between them.
// Output backpressure stalls the input only once both registers are full.
// poll_limit is written via cfg_wr_en/cfg_wr_data; the user must write it only
// while no command is running; the block does not check this. Zero acts as one.
module mmc_spi_command_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// command_index[4:0], argument[36:5], rx_byte[44:37], write_byte[52:45]
	input  logic [55:0] s_tdata,
	// kind[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// tx_byte[7:0], chip_select[8], read_byte[16:9], fault_code[19:17],
	// first_status[27:20], second_status[35:28]
	output logic [39:0] m_tdata,
	// read_valid[0], write_taken[1]
	output logic [1:0]  m_tuser,
	// done_res
	output logic        m_tlast
);

	logic [7:0] poll_limit_q;

	logic        valid_s1;
	logic        kind_s1;
	logic [4:0]  index_s1;
	logic [31:0] arg_s1;
	logic [7:0]  rx_s1;
	logic [7:0]  wb_s1;

	mmcseq_pkg::phase_t phase_q, phase_n;
	logic [12:0] byte_cnt_q, byte_cnt_n;
	logic [7:0]  poll_cnt_q, poll_cnt_n;
	logic [12:0] blk_len_q, blk_len_n;
	logic [12:0] saved_len_q, saved_len_n;
	logic [4:0]  active_ix_q, active_ix_n;
	logic [31:0] held_arg_q, held_arg_n;
	logic [15:0] held_stat_q, held_stat_n;

	mmcseq_pkg::result_t res, res_q;
	logic out_valid_q;
	logic advance;

	assign advance = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_limit_q <= 8'hFF;
		end else if (cfg_wr_en) begin
			poll_limit_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1  <= s_tuser;
			index_s1 <= s_tdata[4:0];
			arg_s1   <= s_tdata[36:5];
			rx_s1    <= s_tdata[44:37];
			wb_s1    <= s_tdata[52:45];
		end
	end

	// next-phase logic
	always_comb begin
		logic [7:0]  lim;
		logic [7:0]  pc_inc;
		logic        spent;
		logic        fin;
		logic [2:0]  fin_err;
		logic        resp_done;
		logic [12:0] base_len;
		logic [12:0] wcnt;
		logic [3:0]  k;
		logic [5:0]  op;

		phase_n     = phase_q;
		byte_cnt_n  = byte_cnt_q;
		poll_cnt_n  = poll_cnt_q;
		blk_len_n   = blk_len_q;
		saved_len_n = saved_len_q;
		active_ix_n = active_ix_q;
		held_arg_n  = held_arg_q;
		held_stat_n = held_stat_q;
		res         = '0;
		res.tx_byte = mmcseq_pkg::IDLE_BYTE;

		lim       = (poll_limit_q == 8'd0) ? 8'd1 : poll_limit_q;
		pc_inc    = (poll_cnt_q != 8'hFF) ? poll_cnt_q + 8'd1 : poll_cnt_q;
		spent     = pc_inc >= lim;
		fin       = 1'b0;
		fin_err   = mmcseq_pkg::ERR_NONE;
		resp_done = 1'b0;
		base_len  = blk_len_q;
		wcnt      = byte_cnt_q;
		k         = byte_cnt_q[3:0] + 4'd1;
		op        = mmcseq_pkg::tab_op(active_ix_q);

		if (!kind_s1) begin
			held_stat_n = '0;
			if (mmcseq_pkg::is_reg_read(active_ix_q) &&
			    (phase_q != mmcseq_pkg::PH_IDLE || index_s1 > mmcseq_pkg::LAST_INDEX)) begin
				base_len = saved_len_q;
			end
			blk_len_n = base_len;
			if (index_s1 > mmcseq_pkg::LAST_INDEX) begin
				phase_n        = mmcseq_pkg::PH_IDLE;
				res.done_res   = 1'b1;
				res.fault_code = mmcseq_pkg::ERR_INDEX;
			end else begin
				active_ix_n = index_s1;
				held_arg_n  = arg_s1;
				if (mmcseq_pkg::tab_op(index_s1) == 6'd16) begin
					base_len = (arg_s1 > 32'(mmcseq_pkg::MAX_BLOCK_LEN)) ?
						mmcseq_pkg::MAX_BLOCK_LEN : arg_s1[12:0];
				end
				if (mmcseq_pkg::is_reg_read(index_s1)) begin
					saved_len_n = base_len;
					blk_len_n   = mmcseq_pkg::REG_BLOCK_LEN;
				end else begin
					blk_len_n = base_len;
				end
				byte_cnt_n      = '0;
				poll_cnt_n      = '0;
				phase_n         = mmcseq_pkg::PH_SEND;
				res.chip_select = 1'b1;
			end
		end else if (phase_q != mmcseq_pkg::PH_IDLE) begin
			unique case (phase_q)
				mmcseq_pkg::PH_SEND: begin
					if (byte_cnt_q < 13'd9) begin
						byte_cnt_n = byte_cnt_q + 13'd1;
						if (k < 4'd4) begin
							res.tx_byte = mmcseq_pkg::IDLE_BYTE;
						end else if (k == 4'd4) begin
							res.tx_byte = {2'b00, op} | mmcseq_pkg::CMD_START_BIT;
						end else if (k < 4'd9) begin
							if (!mmcseq_pkg::tab_has_arg(active_ix_q)) begin
								res.tx_byte = 8'h00;
							end else begin
								case (k)
									4'd5: res.tx_byte = held_arg_q[31:24];
									4'd6: res.tx_byte = held_arg_q[23:16];
									4'd7: res.tx_byte = held_arg_q[15:8];
									default: res.tx_byte = held_arg_q[7:0];
								endcase
							end
						end else begin
							res.tx_byte = (op == 6'd0) ? mmcseq_pkg::CRC_CMD0 :
								mmcseq_pkg::IDLE_BYTE;
						end
					end else begin
						poll_cnt_n = '0;
						phase_n    = mmcseq_pkg::PH_R1;
					end
				end
				mmcseq_pkg::PH_R1: begin
					held_stat_n = {8'h00, rx_s1};
					if (!rx_s1[7]) begin
						poll_cnt_n = '0;
						byte_cnt_n = '0;
						case (mmcseq_pkg::tab_resp(active_ix_q))
							mmcseq_pkg::RS_R1B: phase_n = mmcseq_pkg::PH_BUSY;
							mmcseq_pkg::RS_R2:  phase_n = mmcseq_pkg::PH_R2B;
							mmcseq_pkg::RS_R3:  phase_n = mmcseq_pkg::PH_OCR;
							default:            resp_done = 1'b1;
						endcase
					end else begin
						poll_cnt_n = pc_inc;
						if (spent) begin
							fin     = 1'b1;
							fin_err = mmcseq_pkg::ERR_RESP;
						end
					end
				end
				mmcseq_pkg::PH_BUSY: begin
					if (rx_s1 != 8'h00) begin
						resp_done = 1'b1;
					end else begin
						poll_cnt_n = pc_inc;
						if (spent) begin
							fin     = 1'b1;
							fin_err = mmcseq_pkg::ERR_BUSY;
						end
					end
				end
				mmcseq_pkg::PH_R2B: begin
					held_stat_n = {rx_s1, held_stat_q[7:0]};
					resp_done   = 1'b1;
				end
				mmcseq_pkg::PH_OCR: begin
					res.read_byte  = rx_s1;
					res.read_valid = 1'b1;
					byte_cnt_n     = byte_cnt_q + 13'd1;
					if (byte_cnt_n >= 13'd4) begin
						resp_done = 1'b1;
					end
				end
				mmcseq_pkg::PH_TOKEN: begin
					if (rx_s1 == mmcseq_pkg::START_TOKEN) begin
						byte_cnt_n = '0;
						phase_n = (blk_len_q != 13'd0) ? mmcseq_pkg::PH_RDATA :
							mmcseq_pkg::PH_RCRC1;
					end else begin
						poll_cnt_n = pc_inc;
						if (spent) begin
							fin     = 1'b1;
							fin_err = mmcseq_pkg::ERR_TOKEN;
						end
					end
				end
				mmcseq_pkg::PH_RDATA: begin
					res.read_byte  = rx_s1;
					res.read_valid = 1'b1;
					byte_cnt_n     = byte_cnt_q + 13'd1;
					if (byte_cnt_n >= blk_len_q) begin
						phase_n = mmcseq_pkg::PH_RCRC1;
					end
				end
				mmcseq_pkg::PH_RCRC1: phase_n = mmcseq_pkg::PH_RCRC2;
				mmcseq_pkg::PH_RCRC2: phase_n = mmcseq_pkg::PH_TAIL;
				mmcseq_pkg::PH_WPREP: begin
					res.tx_byte = mmcseq_pkg::START_TOKEN;
					phase_n     = mmcseq_pkg::PH_WTOKEN;
				end
				mmcseq_pkg::PH_WTOKEN, mmcseq_pkg::PH_WDATA: begin
					wcnt = (phase_q == mmcseq_pkg::PH_WTOKEN) ? 13'd0 : byte_cnt_q;
					if (wcnt < blk_len_q) begin
						res.tx_byte     = wb_s1;
						res.write_taken = 1'b1;
						byte_cnt_n      = wcnt + 13'd1;
						phase_n         = mmcseq_pkg::PH_WDATA;
					end else begin
						byte_cnt_n = wcnt;
						phase_n    = mmcseq_pkg::PH_WCRC1;
					end
				end
				mmcseq_pkg::PH_WCRC1: phase_n = mmcseq_pkg::PH_WCRC2;
				mmcseq_pkg::PH_WCRC2: begin
					poll_cnt_n = '0;
					phase_n    = mmcseq_pkg::PH_WRESP;
				end
				mmcseq_pkg::PH_WRESP: begin
					if ((rx_s1 & mmcseq_pkg::DRESP_MASK) == mmcseq_pkg::DRESP_ACCEPT) begin
						poll_cnt_n = '0;
						phase_n    = mmcseq_pkg::PH_WBUSY;
					end else begin
						poll_cnt_n = pc_inc;
						if (spent) begin
							fin     = 1'b1;
							fin_err = mmcseq_pkg::ERR_DRESP;
						end
					end
				end
				mmcseq_pkg::PH_WBUSY: begin
					if (rx_s1 != 8'h00) begin
						phase_n = mmcseq_pkg::PH_EXTRA;
					end else begin
						poll_cnt_n = pc_inc;
						if (spent) begin
							fin     = 1'b1;
							fin_err = mmcseq_pkg::ERR_BUSY;
						end
					end
				end
				mmcseq_pkg::PH_EXTRA: phase_n = mmcseq_pkg::PH_TAIL;
				mmcseq_pkg::PH_TAIL: begin
					fin     = 1'b1;
					fin_err = mmcseq_pkg::ERR_NONE;
				end
				default: phase_n = mmcseq_pkg::PH_IDLE;
			endcase

			if (resp_done) begin
				poll_cnt_n = '0;
				case (mmcseq_pkg::tab_xfer(active_ix_q))
					mmcseq_pkg::XF_READ:  phase_n = mmcseq_pkg::PH_TOKEN;
					mmcseq_pkg::XF_WRITE: phase_n = mmcseq_pkg::PH_WPREP;
					default:              phase_n = mmcseq_pkg::PH_TAIL;
				endcase
			end

			if (fin) begin
				if (mmcseq_pkg::is_reg_read(active_ix_q)) begin
					blk_len_n = saved_len_q;
				end
				phase_n           = mmcseq_pkg::PH_IDLE;
				res.tx_byte       = mmcseq_pkg::IDLE_BYTE;
				res.done_res      = 1'b1;
				res.fault_code    = fin_err;
				res.first_status  = held_stat_n[7:0];
				res.second_status = held_stat_n[15:8];
			end else begin
				res.chip_select = 1'b1;
			end
		end
	end

	// state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= mmcseq_pkg::PH_IDLE;
			byte_cnt_q  <= '0;
			poll_cnt_q  <= '0;
			blk_len_q   <= mmcseq_pkg::RESET_BLOCK_LEN;
			saved_len_q <= mmcseq_pkg::RESET_BLOCK_LEN;
			active_ix_q <= '0;
			held_arg_q  <= '0;
			held_stat_q <= '0;
			out_valid_q <= 1'b0;
		end else if (valid_s1 && advance) begin
			phase_q     <= phase_n;
			byte_cnt_q  <= byte_cnt_n;
			poll_cnt_q  <= poll_cnt_n;
			blk_len_q   <= blk_len_n;
			saved_len_q <= saved_len_n;
			active_ix_q <= active_ix_n;
			held_arg_q  <= held_arg_n;
			held_stat_q <= held_stat_n;
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, res_q.second_status, res_q.first_status, res_q.fault_code,
		res_q.read_byte, res_q.chip_select, res_q.tx_byte};
	assign m_tuser  = {res_q.write_taken, res_q.read_valid};
	assign m_tlast  = res_q.done_res;

	// error and status only travel on the closing transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.done_res |-> res_q.fault_code == mmcseq_pkg::ERR_NONE &&
			res_q.first_status == 8'h00 && res_q.second_status == 8'h00)
		else $error("status reported before sequence end");

	// a finished sequence leaves the card deselected
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.done_res |-> !res_q.chip_select)
		else $error("chip select held on sequence end");

	// reads and writes never share a transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.read_valid && res_q.write_taken))
		else $error("read and write in one transaction");

	// a done result always returns the engine to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && res.done_res |=> phase_q == mmcseq_pkg::PH_IDLE)
		else $error("engine not idle after sequence end");

endmodule
